>>> src/tci_pkg.sv
// ---------------------------------------------------------------------------
// tci_pkg: throttle curve interpolator shared definitions
// curve tables, drive modes, register indexes and field widths
// ---------------------------------------------------------------------------
`default_nettype none

package tci_pkg;

	localparam int ThrottleW = 16;
	localparam int LevelW    = 12;
	localparam int CustomW   = 56;
	localparam int PointW    = 16;
	localparam int SegW      = 3;
	localparam int FracW     = 9;
	localparam int XW        = SegW + FracW;
	localparam int ClampW    = 13;
	localparam int WeightW   = FracW + 1;
	localparam int ProdW     = PointW + WeightW;
	localparam int SumW      = ProdW + 1;

	localparam logic [ClampW-1:0]  FULL_IN   = 13'h1000;
	localparam logic [WeightW-1:0] FRAC_ONE  = 10'h200;
	localparam logic [LevelW-1:0]  LEVEL_MAX = 12'hfff;

	typedef enum logic [1:0] {
		MODE_SOFT   = 2'd0,
		MODE_ECO    = 2'd1,
		MODE_RACING = 2'd2,
		MODE_CUSTOM = 2'd3
	} drive_mode_t;

	typedef enum logic {
		REG_DRIVE_MODE    = 1'b0,
		REG_CUSTOM_POINTS = 1'b1
	} reg_index_t;

	localparam logic [PointW-1:0] SOFT_CURVE [8] = '{
		16'd9824, 16'd12823, 16'd15560, 16'd19656,
		16'd24023, 16'd28391, 16'd32760, 16'd32760
	};
	localparam logic [PointW-1:0] ECO_CURVE [8] = '{
		16'd9824, 16'd12823, 16'd15560, 16'd19656,
		16'd24023, 16'd26208, 16'd26208, 16'd26208
	};
	localparam logic [PointW-1:0] RACING_POINT = 16'd32768;

	// custom point i is byte i << 7, last point repeats point 6
	function automatic logic [PointW-1:0] curve_point(
		input drive_mode_t        mode,
		input logic [SegW-1:0]    idx,
		input logic [CustomW-1:0] custom
	);
		logic [SegW-1:0]   cidx;
		logic [7:0]        cbyte;
		logic [PointW-1:0] pt;
		cidx  = (idx == 3'd7) ? 3'd6 : idx;
		cbyte = custom[{cidx, 3'b000} +: 8];
		unique case (mode)
			MODE_SOFT:   pt = SOFT_CURVE[idx];
			MODE_ECO:    pt = ECO_CURVE[idx];
			MODE_RACING: pt = RACING_POINT;
			MODE_CUSTOM: pt = {1'b0, cbyte, 7'b0000000};
			default:     pt = '0;
		endcase
		return pt;
	endfunction

endpackage

`default_nettype wire

>>> src/throttle_curve_interpolator_core.sv
// ---------------------------------------------------------------------------
// throttle_curve_interpolator_core: piecewise linear drive curve
// clamps and scales a throttle beat, interpolates an 8-point curve
// ---------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  s_axis    in   tvalid/tready         tdata[15:0] throttle_in (signed)
//  m_axis    out  tvalid/tready         tdata[11:0] drive_level, [15:12] zero
//  cfg       in   cfg_valid/cfg_ready   cfg_index, cfg_data[55:0]
//
//  four register stages: clamp+scale, curve lookup, two multiplies, sum+saturate
//  one beat per cycle sustained while m_axis_tready stays high
//  each stage holds its beat while the stage after it is full and stalled
//  arst_n clears the valid bits and the registers (soft mode, custom zero)
//  cfg_ready is always high; registers are to be written only while idle (the user must see to it; not enforced)
`default_nettype none

module throttle_curve_interpolator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [15:0] throttle_in
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // [11:0] drive_level, [15:12] zero
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [55:0] cfg_data
);

	tci_pkg::drive_mode_t                 drive_mode_q;
	logic [tci_pkg::CustomW-1:0]          custom_points_q;

	logic                                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic                                 ready_s1, ready_s2, ready_s3, ready_s4;

	logic [tci_pkg::XW-1:0]               x_s1;
	logic [tci_pkg::PointW-1:0]           p0_s2, p1_s2;
	logic [tci_pkg::FracW-1:0]            frac_s2;
	logic [tci_pkg::ProdW-1:0]            prod0_s3, prod1_s3;
	logic [tci_pkg::LevelW-1:0]           level_s4;

	logic [tci_pkg::ClampW-1:0]           t_clamp;
	logic [tci_pkg::ClampW+1:0]           t_times7;
	logic [tci_pkg::SegW-1:0]             seg;
	logic [tci_pkg::SegW-1:0]             seg_next;
	logic [tci_pkg::FracW-1:0]            frac;
	logic [tci_pkg::SumW-1:0]             sum;
	logic [tci_pkg::SumW-13:0]            sum_shr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_mode_q    <= tci_pkg::MODE_SOFT;
			custom_points_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (tci_pkg::reg_index_t'(cfg_index))
				tci_pkg::REG_DRIVE_MODE:
					drive_mode_q <= tci_pkg::drive_mode_t'(cfg_data[1:0]);
				tci_pkg::REG_CUSTOM_POINTS:
					custom_points_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage may load when empty or when its beat moves on
	assign ready_s4      = !valid_s4 || m_axis_tready;
	assign ready_s3      = !valid_s3 || ready_s4;
	assign ready_s2      = !valid_s2 || ready_s3;
	assign ready_s1      = !valid_s1 || ready_s2;
	assign s_axis_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= s_axis_tvalid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: clamp to 0..4096, scale by 7/8
	always_comb begin
		if (s_axis_tdata[15])
			t_clamp = '0;
		else if (s_axis_tdata[14:0] > {2'b00, tci_pkg::FULL_IN})
			t_clamp = tci_pkg::FULL_IN;
		else
			t_clamp = s_axis_tdata[tci_pkg::ClampW-1:0];
		// 7 * 4096 still fits, the dropped top bit is always zero
		t_times7 = (tci_pkg::ClampW+2)'({t_clamp, 3'b000} - {3'b000, t_clamp});
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_axis_tvalid)
			x_s1 <= t_times7[tci_pkg::ClampW+1:3];
	end

	// stage 2: fetch both segment end points
	assign seg      = x_s1[tci_pkg::XW-1:tci_pkg::FracW];
	assign frac     = x_s1[tci_pkg::FracW-1:0];
	// wraps at segment 7, whose fraction is always zero
	assign seg_next = seg + 3'd1;

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			p0_s2   <= tci_pkg::curve_point(drive_mode_q, seg, custom_points_q);
			p1_s2   <= tci_pkg::curve_point(drive_mode_q, seg_next, custom_points_q);
			frac_s2 <= frac;
		end
	end

	// stage 3: weight each point
	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			prod0_s3 <= p0_s2 * (tci_pkg::FRAC_ONE - {1'b0, frac_s2});
			prod1_s3 <= p1_s2 * {1'b0, frac_s2};
		end
	end

	// stage 4: add, drop 12 bits, saturate
	assign sum     = {1'b0, prod0_s3} + {1'b0, prod1_s3};
	assign sum_shr = sum[tci_pkg::SumW-1:12];

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			if (sum_shr > {3'b000, tci_pkg::LEVEL_MAX})
				level_s4 <= tci_pkg::LEVEL_MAX;
			else
				level_s4 <= sum_shr[tci_pkg::LevelW-1:0];
		end
	end

	assign m_axis_tvalid = valid_s4;
	assign m_axis_tdata  = {4'b0000, level_s4};

	a_seg7_no_frac: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && seg == 3'd7 |-> frac == '0)
		else $error("segment 7 with nonzero fraction");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1 && $stable(x_s1))
		else $error("stage 1 beat changed while stalled");

	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && valid_s4 && !m_axis_tready |=> valid_s3 && $stable(prod0_s3)
			&& $stable(prod1_s3))
		else $error("stage 3 beat lost behind stalled output");

endmodule

`default_nettype wire

>>> sim/drive_level_checker.sv
// ---------------------------------------------------------------------------
// drive_level_checker: scoreboard for the throttle curve interpolator
// tracks the mode and custom curve from cfg writes, predicts the drive
// level of every accepted throttle beat and compares it with m_axis in order
// ---------------------------------------------------------------------------
module drive_level_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [15:0] throttle_in
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [15:0] m_axis_tdata,  // [11:0] drive_level, [15:12] zero
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [55:0] cfg_data,
	output int unsigned      mismatches,
	output int unsigned      levels_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          THROTTLE_FULL = 4096;
	localparam int          SCALE_7_8     = 28672;
	localparam int unsigned FRAC_MASK     = 'h1ff;
	localparam int unsigned FRAC_ONE      = 'h200;
	localparam int unsigned LEVEL_TOP     = 'hfff;

	localparam logic [15:0] SOFT_PTS [8] = '{
		16'd9824, 16'd12823, 16'd15560, 16'd19656,
		16'd24023, 16'd28391, 16'd32760, 16'd32760
	};
	localparam logic [15:0] ECO_PTS [8] = '{
		16'd9824, 16'd12823, 16'd15560, 16'd19656,
		16'd24023, 16'd26208, 16'd26208, 16'd26208
	};
	localparam logic [15:0] RACING_PT = 16'd32768;

	tci_pkg::drive_mode_t cur_mode;
	logic [55:0] cur_custom;
	logic [11:0] levels_due [$];
	int unsigned err_cnt;

	function automatic logic [15:0] point_at(tci_pkg::drive_mode_t m, int unsigned i,
			logic [55:0] cp);
		case (m)
			tci_pkg::MODE_SOFT:   return SOFT_PTS[i];
			tci_pkg::MODE_ECO:    return ECO_PTS[i];
			tci_pkg::MODE_RACING: return RACING_PT;
			default: begin
				// custom curve: the last point repeats point 6
				if (i > 6)
					i = 6;
				return {1'b0, cp[8*i +: 8], 7'b0000000};
			end
		endcase
	endfunction

	function automatic logic [11:0] drive_level_for(logic signed [15:0] thr,
			tci_pkg::drive_mode_t m, logic [55:0] cp);
		int          t;
		int unsigned x, seg, frac, acc;
		t = thr;
		if (t < 0)
			t = 0;
		if (t > THROTTLE_FULL)
			t = THROTTLE_FULL;
		x    = int'(t * SCALE_7_8) >> 15;
		seg  = x >> 9;
		frac = x & FRAC_MASK;
		acc  = point_at(m, seg, cp) * (FRAC_ONE - frac);
		// segment 7 at zero fraction has no upper point
		if (frac != 0 && seg < 7)
			acc += point_at(m, seg + 1, cp) * frac;
		acc = acc >> 12;
		if (acc > LEVEL_TOP)
			acc = LEVEL_TOP;
		return acc[11:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [11:0] want;
		if (!arst_n) begin
			cur_mode = tci_pkg::MODE_SOFT;
			cur_custom = '0;
			levels_due.delete();
			err_cnt = 0;
			mismatches <= 0;
			levels_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (tci_pkg::reg_index_t'(cfg_index))
					tci_pkg::REG_DRIVE_MODE:
						cur_mode = tci_pkg::drive_mode_t'(cfg_data[1:0]);
					tci_pkg::REG_CUSTOM_POINTS:
						cur_custom = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (levels_due.size() == 0) begin
					$error("drive_level: beat 0x%0h with nothing expected", m_axis_tdata);
					err_cnt++;
				end else begin
					want = levels_due.pop_front();
					if (m_axis_tdata[11:0] !== want) begin
						$error("drive_level: expected %0d, got %0d", want, m_axis_tdata[11:0]);
						err_cnt++;
					end
					if (m_axis_tdata[15:12] !== 4'h0) begin
						$error("tdata pad: expected 0, got 0x%0h", m_axis_tdata[15:12]);
						err_cnt++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				levels_due.push_back(drive_level_for($signed(s_axis_tdata), cur_mode, cur_custom));
			mismatches <= err_cnt;
			levels_pending <= levels_due.size();
		end
	end

endmodule

>>> sim/throttle_curve_interpolator_core_test.sv
// ---------------------------------------------------------------------------
// throttle_curve_interpolator_core_test: top of the interpolator bench
// drives throttle beats through every drive mode and custom curve, with random
// gaps and back-pressure in all but one phase; the checker predicts and compares levels
// ---------------------------------------------------------------------------
module throttle_curve_interpolator_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int BEATS_PER_PHASE = 125;
	localparam int PHASES = 8;

	localparam logic [15:0] EDGE_THROTTLE [14] = '{
		16'h8000, 16'hffff, 16'd0, 16'd1, 16'd585, 16'd586, 16'd2048,
		16'd2340, 16'd3000, 16'd4095, 16'd4096, 16'd4097, 16'h7fff, 16'd1000
	};

	localparam tci_pkg::drive_mode_t PHASE_MODE [PHASES] = '{
		tci_pkg::MODE_RACING, tci_pkg::MODE_CUSTOM, tci_pkg::MODE_CUSTOM, tci_pkg::MODE_ECO,
		tci_pkg::MODE_SOFT, tci_pkg::MODE_CUSTOM, tci_pkg::MODE_RACING, tci_pkg::MODE_CUSTOM
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	tci_pkg::reg_index_t cfg_index = tci_pkg::REG_DRIVE_MODE;
	logic [55:0] cfg_data = '0;

	logic        idle_on = 1'b1;
	int unsigned quiet_cycles = 0;
	int unsigned mismatches;
	int unsigned levels_pending;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	throttle_curve_interpolator_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	drive_level_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.levels_pending (levels_pending)
	);

	// receiver back-pressure
	always @(posedge clk)
		m_axis_tready <= idle_on ? ($urandom_range(99) >= 16) : 1'b1;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [15:0] pick_throttle();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60)
			return 16'($urandom_range(4096));
		else if (r < 65)
			return 16'($urandom_range(16));
		else if (r < 72)
			return 16'($urandom_range(4100, 4080));
		return 16'($urandom());
	endfunction

	task automatic send_throttle(input logic [15:0] v);
		while (idle_on && $urandom_range(99) < 16) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// hold off the sender until every level has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (levels_pending != 0)
			@(posedge clk);
	endtask

	// leaves cfg_valid high so back-to-back writes need no toggle
	task automatic write_reg(input tci_pkg::reg_index_t idx, input logic [55:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	initial begin
		logic [55:0] mode_word;
		logic [55:0] curve;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset curve is soft
		foreach (EDGE_THROTTLE[i])
			send_throttle(EDGE_THROTTLE[i]);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			idle_on <= (p != 3);
			mode_word = {24'($urandom()), 32'($urandom())};
			mode_word[1:0] = PHASE_MODE[p];
			if (p == 1)
				curve = {56{1'b1}};
			else if (p == 2)
				curve = '0;
			else
				curve = {24'($urandom()), 32'($urandom())};
			write_reg(tci_pkg::REG_DRIVE_MODE, mode_word);
			write_reg(tci_pkg::REG_CUSTOM_POINTS, curve);
			cfg_valid <= 1'b0;
			repeat (BEATS_PER_PHASE)
				send_throttle(pick_throttle());
		end

		drain();
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> files.f
src/tci_pkg.sv
src/throttle_curve_interpolator_core.sv
sim/drive_level_checker.sv
sim/throttle_curve_interpolator_core_test.sv
